[design/srcnt_pkg.sv]
// shared types and constants for the sorted range counter
`default_nettype none
package srcnt_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 11;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_SORT  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_SRCH_CHK,
        ST_SRCH_CMP
    } state_t;

endpackage
`default_nettype wire

[design/srcnt_ram.sv]
// simple dual port synchronous ram, one write and one registered read
`default_nettype none
module srcnt_ram
    import srcnt_pkg::*;
#(
    parameter int DEPTH = MAX_POINTS_DEF,
    parameter int AW    = 10
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[design/sorted_range_count_top.sv]
// sorted range counter: point store with merge sort and range queries
//
// command channel: an item is taken when start is high and busy is low.
// action clear empties the store, load appends value (dropped when full),
// sort orders the store ascending, query counts points in [value, upper].
// clear and load give no word.
// sort is a bottom-up merge over the point ram with a half size scratch
// ram; copying the right run takes a read and a write per point, then the
// merge takes a read and a write per output point.
// a query runs two binary searches on the single read port of the point
// ram, a check and a compare state per probe, and is never busy when
// value > upper. the word appears on count with done high for one cycle,
// in the cycle after the search ends; the receiver cannot stall.
// reset empties the store; ram contents are left as they are.
`default_nettype none
module sorted_range_count_top
    import srcnt_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               action,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic signed [DATA_W-1:0] upper,
    output logic                          done,
    output logic      [COUNT_W-1:0]       count
);

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int XW  = CW + 2;
    localparam int SCR = MAX_POINTS / 2;
    localparam int SAW = (SCR > 1) ? $clog2(SCR) : 1;

    state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [XW-1:0]  w_reg, w_next, lo_reg, lo_next;
    logic [CW-1:0]  t_reg, t_next, r_reg, r_next;
    logic [CW-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic           ldone_reg, ldone_next;
    logic [CW-1:0]  slo_reg, slo_next, shi_reg, shi_next, mi_reg, mi_next, ub_reg, ub_next;
    logic           phase_reg, phase_next;
    logic signed [DATA_W-1:0] lkey_reg, lkey_next, hkey_reg, hkey_next;
    logic           done_reg, done_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic              st_we, sc_we;
    logic [AW-1:0]     st_waddr, st_raddr;
    logic [SAW-1:0]    sc_waddr, sc_raddr;
    logic [DATA_W-1:0] st_wdata, st_rdata, sc_rdata;

    logic            accept;
    logic [XW-1:0]   n_x, rem, r_calc, copy_addr;
    logic            pass_done, run_short, copy_last, take_left, merge_last;
    logic            srch_go, go_right;
    logic [CW-1:0]   mi_calc;
    logic [CW:0]     diff;

    assign accept    = start && !busy;
    assign n_x       = XW'(cnt_reg);
    assign pass_done = w_reg >= n_x;
    assign run_short = (lo_reg + w_reg) >= n_x;
    assign rem       = n_x - lo_reg - w_reg;
    assign r_calc    = (rem > w_reg) ? w_reg : rem;
    assign copy_addr = lo_reg + w_reg + XW'(t_reg);
    assign copy_last = t_reg == (r_reg - CW'(1));
    assign take_left = !ldone_reg && ($signed(st_rdata) > $signed(sc_rdata));
    assign merge_last = !take_left && (j_reg == '0);
    assign srch_go   = slo_reg < shi_reg;
    assign mi_calc   = slo_reg + ((shi_reg - slo_reg) >> 1);
    assign go_right  = phase_reg ? ($signed(st_rdata) < lkey_reg)
                                 : ($signed(st_rdata) <= hkey_reg);
    assign diff      = {1'b0, ub_reg} - {1'b0, slo_reg};

    srcnt_ram #(.DEPTH(MAX_POINTS), .AW(AW)) u_points (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    srcnt_ram #(.DEPTH((SCR > 0) ? SCR : 1), .AW(SAW)) u_scratch (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (st_rdata),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        lo_reg    <= lo_next;
        t_reg     <= t_next;
        r_reg     <= r_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        ldone_reg <= ldone_next;
        slo_reg   <= slo_next;
        shi_reg   <= shi_next;
        mi_reg    <= mi_next;
        ub_reg    <= ub_next;
        phase_reg <= phase_next;
        lkey_reg  <= lkey_next;
        hkey_reg  <= hkey_next;
        count_reg <= count_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_SORT)
                begin
                    state_next = ST_SORT_CHK;
                end
                else if (accept && action == ACT_QUERY && !(value > upper))
                begin
                    state_next = ST_SRCH_CHK;
                end
            end
            ST_SORT_CHK:
            begin
                if (pass_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (!run_short)
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_COPY_RD:  state_next = ST_COPY_WR;
            ST_COPY_WR:  state_next = copy_last ? ST_MRG_RD : ST_COPY_RD;
            ST_MRG_RD:   state_next = ST_MRG_WR;
            ST_MRG_WR:   state_next = merge_last ? ST_SORT_CHK : ST_MRG_RD;
            ST_SRCH_CHK:
            begin
                if (srch_go)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (phase_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH_CMP: state_next = ST_SRCH_CHK;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and ram controls
    always_comb
    begin
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        lo_next    = lo_reg;
        t_next     = t_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ldone_next = ldone_reg;
        slo_next   = slo_reg;
        shi_next   = shi_reg;
        mi_next    = mi_reg;
        ub_next    = ub_reg;
        phase_next = phase_reg;
        lkey_next  = lkey_reg;
        hkey_next  = hkey_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        st_we      = 1'b0;
        st_waddr   = i_reg[AW-1:0];
        st_wdata   = value;
        st_raddr   = i_reg[AW-1:0];
        sc_we      = 1'b0;
        sc_waddr   = t_reg[SAW-1:0];
        sc_raddr   = j_reg[SAW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                lkey_next  = value;
                hkey_next  = upper;
                w_next     = XW'(1);
                lo_next    = '0;
                slo_next   = '0;
                shi_next   = cnt_reg;
                phase_next = 1'b0;
                if (accept)
                begin
                    unique case (action_t'(action))
                        ACT_CLEAR: cnt_next = '0;
                        ACT_LOAD:
                        begin
                            if (cnt_reg < CW'(MAX_POINTS))
                            begin
                                st_we    = 1'b1;
                                st_waddr = cnt_reg[AW-1:0];
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        ACT_SORT:  ;
                        ACT_QUERY:
                        begin
                            if (value > upper)
                            begin
                                done_next  = 1'b1;
                                count_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SORT_CHK:
            begin
                if (run_short)
                begin
                    w_next  = {w_reg[XW-2:0], 1'b0};
                    lo_next = '0;
                end
                else
                begin
                    r_next = r_calc[CW-1:0];
                    t_next = '0;
                end
            end
            ST_COPY_RD:
            begin
                st_raddr = copy_addr[AW-1:0];
            end
            ST_COPY_WR:
            begin
                sc_we  = 1'b1;
                t_next = t_reg + CW'(1);
                // right run now in scratch, set up the top-down merge
                i_next = CW'(lo_reg + w_reg - XW'(1));
                j_next = r_reg - CW'(1);
                k_next = CW'(lo_reg + w_reg + XW'(r_reg) - XW'(1));
                ldone_next = 1'b0;
            end
            ST_MRG_RD:
            begin
                st_raddr = i_reg[AW-1:0];
                sc_raddr = j_reg[SAW-1:0];
            end
            ST_MRG_WR:
            begin
                st_we    = 1'b1;
                st_waddr = k_reg[AW-1:0];
                st_wdata = take_left ? st_rdata : sc_rdata;
                k_next   = k_reg - CW'(1);
                if (take_left)
                begin
                    if (i_reg == CW'(lo_reg))
                    begin
                        ldone_next = 1'b1;
                    end
                    else
                    begin
                        i_next = i_reg - CW'(1);
                    end
                end
                else if (j_reg == '0)
                begin
                    lo_next = lo_reg + {w_reg[XW-2:0], 1'b0};
                end
                else
                begin
                    j_next = j_reg - CW'(1);
                end
            end
            ST_SRCH_CHK:
            begin
                st_raddr = mi_calc[AW-1:0];
                mi_next  = mi_calc;
                if (!srch_go)
                begin
                    if (!phase_reg)
                    begin
                        // upper bound found, now search the lower bound
                        ub_next    = slo_reg;
                        phase_next = 1'b1;
                        slo_next   = '0;
                        shi_next   = cnt_reg;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        count_next = diff[CW] ? '0 : COUNT_W'(diff[CW-1:0]);
                    end
                end
            end
            ST_SRCH_CMP:
            begin
                if (go_right)
                begin
                    slo_next = mi_reg + CW'(1);
                end
                else
                begin
                    shi_next = mi_reg;
                end
            end
            default: ;
        endcase
    end

    assign busy  = state_reg != ST_IDLE;
    assign done  = done_reg;
    assign count = count_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("word without a command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> COUNT_W'(cnt_reg) >= count || CW > COUNT_W)
        else $error("count above stored points");

    a_store_stable: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(cnt_reg))
        else $error("point count changed during sort or query");

endmodule
`default_nettype wire
